// ----- rtl/bca_pkg.sv -----
// bca_pkg: shared types and constants of the affine band combine block
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package bca_pkg;

    localparam int BANDS      = 4;
    localparam int TABLE_CAP  = BANDS * (BANDS + 1);

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;
    localparam logic [31:0] DEFAULT_NAN = 32'hFFC0_0000;

    typedef struct packed {
        logic                   valid;
        logic [BANDS-1:0][31:0] src;
        logic [BANDS-1:0][31:0] acc;
    } bca_token_t;

endpackage

// ----- rtl/bca_fmul.sv -----
// bca_fmul: two-stage float32 multiplier, round to nearest even
// depends on bca_pkg
`timescale 1ns / 1ps

module bca_fmul (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] y
);
    import bca_pkg::*;

    logic               sign_reg, sign_next;
    logic               special_reg, special_next;
    logic [31:0]        spec_reg, spec_next;
    logic signed [10:0] es_reg, es_next;
    logic [47:0]        prod_reg, prod_next;
    logic [31:0]        y_reg, y_next;

    logic [7:0]  ea, eb, ea_eff, eb_eff;
    logic [23:0] ma, mb;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;

    always_comb
    begin
        ea     = a[30:23];
        eb     = b[30:23];
        a_nan  = (ea == 8'hFF) && (a[22:0] != 23'd0);
        b_nan  = (eb == 8'hFF) && (b[22:0] != 23'd0);
        a_inf  = (ea == 8'hFF) && (a[22:0] == 23'd0);
        b_inf  = (eb == 8'hFF) && (b[22:0] == 23'd0);
        a_zero = (a[30:0] == 31'd0);
        b_zero = (b[30:0] == 31'd0);
        ma     = {ea != 8'd0, a[22:0]};
        mb     = {eb != 8'd0, b[22:0]};
        ea_eff = (ea == 8'd0) ? 8'd1 : ea;
        eb_eff = (eb == 8'd0) ? 8'd1 : eb;
        sign_next    = a[31] ^ b[31];
        special_next = 1'b1;
        spec_next    = '0;
        if (a_nan)
            spec_next = a | QUIET_BIT;
        else if (b_nan)
            spec_next = b | QUIET_BIT;
        else if ((a_inf && b_zero) || (b_inf && a_zero))
            spec_next = DEFAULT_NAN;
        else if (a_inf || b_inf)
            spec_next = {sign_next, 8'hFF, 23'd0};
        else if (a_zero || b_zero)
            spec_next = {sign_next, 31'd0};
        else
            special_next = 1'b0;
        es_next   = $signed({3'b000, ea_eff}) + $signed({3'b000, eb_eff}) - 11'sd126;
        prod_next = ma * mb;
    end

    logic [5:0]         lz, sh;
    logic               found, lost, g, st, rnd;
    logic [47:0]        x, yv;
    logic signed [10:0] e;
    logic [7:0]         ef;
    logic [22:0]        mant;

    always_comb
    begin
        lz    = '0;
        found = 1'b0;
        for (int i = 47; i >= 0; i--)
        begin
            if (!found && prod_reg[i])
            begin
                lz    = 6'(47 - i);
                found = 1'b1;
            end
        end
        x  = prod_reg << lz;
        e  = es_reg - $signed({5'b00000, lz});
        sh = '0;
        if (e <= 0)
        begin
            if (e < -46)
                sh = 6'd48;
            else
                sh = 6'(11'sd1 - e);
        end
        yv   = x >> sh;
        lost = |(x & ~({48{1'b1}} << sh));
        ef   = (e > 0) ? e[7:0] : 8'd0;
        mant = yv[46:24];
        g    = yv[23];
        st   = (|yv[22:0]) | lost;
        rnd  = g & (st | mant[0]);
        if (special_reg)
            y_next = spec_reg;
        else if (e >= 255)
            y_next = {sign_reg, 8'hFF, 23'd0};
        else
            y_next = {sign_reg, {ef, mant} + 31'(rnd)};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sign_reg    <= sign_next;
            special_reg <= special_next;
            spec_reg    <= spec_next;
            es_reg      <= es_next;
            prod_reg    <= prod_next;
            y_reg       <= y_next;
        end
    end

    assign y = y_reg;

endmodule

// ----- rtl/bca_fadd.sv -----
// bca_fadd: two-stage float32 adder, round to nearest even
// depends on bca_pkg
`timescale 1ns / 1ps

module bca_fadd (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] y
);
    import bca_pkg::*;

    logic        sign_reg, sign_next;
    logic        special_reg, special_next;
    logic [31:0] spec_reg, spec_next;
    logic [7:0]  exp_reg, exp_next;
    logic [27:0] sum_reg, sum_next;
    logic [31:0] y_reg, y_next;

    logic [7:0]  ea, eb, e_big, e_small, d;
    logic [31:0] big, small_op;
    logic [26:0] big27, small27, shifted, sm;
    logic [4:0]  dsh;
    logic        a_nan, b_nan, a_inf, b_inf, same, lost_a;

    always_comb
    begin
        ea    = a[30:23];
        eb    = b[30:23];
        a_nan = (ea == 8'hFF) && (a[22:0] != 23'd0);
        b_nan = (eb == 8'hFF) && (b[22:0] != 23'd0);
        a_inf = (ea == 8'hFF) && (a[22:0] == 23'd0);
        b_inf = (eb == 8'hFF) && (b[22:0] == 23'd0);
        same  = (a[31] == b[31]);
        special_next = 1'b1;
        spec_next    = '0;
        if (a_nan)
            spec_next = a | QUIET_BIT;
        else if (b_nan)
            spec_next = b | QUIET_BIT;
        else if (a_inf && b_inf && !same)
            spec_next = DEFAULT_NAN;
        else if (a_inf)
            spec_next = a;
        else if (b_inf)
            spec_next = b;
        else
            special_next = 1'b0;
        if (a[30:0] >= b[30:0])
        begin
            big      = a;
            small_op = b;
        end
        else
        begin
            big      = b;
            small_op = a;
        end
        e_big   = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        e_small = (small_op[30:23] == 8'd0) ? 8'd1 : small_op[30:23];
        d       = e_big - e_small;
        dsh     = (d >= 8'd27) ? 5'd27 : d[4:0];
        big27   = {big[30:23] != 8'd0, big[22:0], 3'b000};
        small27 = {small_op[30:23] != 8'd0, small_op[22:0], 3'b000};
        shifted = small27 >> dsh;
        lost_a  = |(small27 & ~({27{1'b1}} << dsh));
        sm      = shifted | {26'd0, lost_a};
        if (same)
            sum_next = {1'b0, big27} + {1'b0, sm};
        else
            sum_next = {1'b0, big27} - {1'b0, sm};
        exp_next = e_big;
        if (sum_next == 28'd0)
            sign_next = same ? a[31] : 1'b0;
        else
            sign_next = big[31];
    end

    logic [4:0]  lz, shift;
    logic        found, g, st, rnd;
    logic [7:0]  lim8, ef;
    logic [8:0]  e9;
    logic [26:0] n;
    logic [22:0] mant;

    always_comb
    begin
        lz    = 5'd27;
        found = 1'b0;
        for (int i = 26; i >= 0; i--)
        begin
            if (!found && sum_reg[i])
            begin
                lz    = 5'(26 - i);
                found = 1'b1;
            end
        end
        lim8  = exp_reg - 8'd1;
        shift = ({3'b000, lz} < lim8) ? lz : lim8[4:0];
        if (sum_reg[27])
        begin
            n  = sum_reg[27:1] | {26'd0, sum_reg[0]};
            e9 = {1'b0, exp_reg} + 9'd1;
        end
        else
        begin
            n  = sum_reg[26:0] << shift;
            e9 = {1'b0, exp_reg} - {4'b0000, shift};
        end
        ef   = n[26] ? e9[7:0] : 8'd0;
        mant = n[25:3];
        g    = n[2];
        st   = |n[1:0];
        rnd  = g & (st | mant[0]);
        if (special_reg)
            y_next = spec_reg;
        else if (e9 >= 9'd255)
            y_next = {sign_reg, 8'hFF, 23'd0};
        else
            y_next = {sign_reg, {ef, mant} + 31'(rnd)};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sign_reg    <= sign_next;
            special_reg <= special_next;
            spec_reg    <= spec_next;
            exp_reg     <= exp_next;
            sum_reg     <= sum_next;
            y_reg       <= y_next;
        end
    end

    assign y = y_reg;

endmodule

// ----- rtl/bca_cell.sv -----
// bca_cell: one multiply-accumulate step over all destination bands
// depends on bca_pkg, bca_fmul, bca_fadd
`timescale 1ns / 1ps

module bca_cell (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  bca_pkg::bca_token_t                  tok_in,
    input  logic [31:0]                          operand,
    input  logic                                 active,
    input  logic [bca_pkg::BANDS-1:0][31:0]      coef,
    output bca_pkg::bca_token_t                  tok_out,
    output logic                                 busy
);
    import bca_pkg::*;

    bca_token_t             tok_pipe_reg [0:3];
    logic [BANDS-1:0][31:0] prod, sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                tok_pipe_reg[i] <= '0;
        end
        else if (en)
        begin
            tok_pipe_reg[0] <= tok_in;
            for (int i = 1; i < 4; i++)
                tok_pipe_reg[i] <= tok_pipe_reg[i-1];
        end
    end

    for (genvar m = 0; m < BANDS; m++)
    begin : g_lane
        bca_fmul u_mul (
            .clk (clk),
            .en  (en),
            .a   (coef[m]),
            .b   (operand),
            .y   (prod[m])
        );
        bca_fadd u_add (
            .clk (clk),
            .en  (en),
            .a   (tok_pipe_reg[1].acc[m]),
            .b   (prod[m]),
            .y   (sum[m])
        );
    end

    always_comb
    begin
        tok_out = tok_pipe_reg[3];
        if (active)
            tok_out.acc = sum;
    end

    assign busy = tok_pipe_reg[0].valid | tok_pipe_reg[1].valid
                | tok_pipe_reg[2].valid | tok_pipe_reg[3].valid;

endmodule

// ----- rtl/band_combine_affine_matrix_top.sv -----
// band_combine_affine_matrix_top: affine band combine on float32 pixels
// depends on bca_pkg, bca_cell, bca_fadd
`timescale 1ns / 1ps

// Input channel (in_valid/in_ready) carries write items (operation 0: store
// coef_value at coef_index) and pixel items (operation 1: src_band0..3).
// Each pixel gives one transfer on the output channel (out_valid/out_ready)
// with dst_band0..3; bands at or beyond dst_band_count (clamped to 1..min(MAX_BANDS,4)) read zero.
// The matrix runs through a chain of cells, one per source band, each a
// multiplier followed by an adder, then an adder for the constant column
// and an output register. One pixel per cycle is sustained while the
// output is not stalled. A write transfer is taken only once no pixel is
// in flight in the chain.
// When the receiver stalls, the whole chain holds and in_ready drops;
// the pending result stays on the output until taken.
// Reset clears the pipeline valids and sets both band counts to 3; the
// coefficient table is not cleared and must be written before use.
// The APB port holds src_band_count at 0x0 and dst_band_count at 0x4.
module band_combine_affine_matrix_top #(
    parameter int MAX_BANDS = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        operation,
    input  logic [4:0]  coef_index,
    input  logic [31:0] coef_value,
    input  logic [31:0] src_band0,
    input  logic [31:0] src_band1,
    input  logic [31:0] src_band2,
    input  logic [31:0] src_band3,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] dst_band0,
    output logic [31:0] dst_band1,
    output logic [31:0] dst_band2,
    output logic [31:0] dst_band3
);
    import bca_pkg::*;

    localparam int LIM        = (MAX_BANDS < BANDS) ? MAX_BANDS : BANDS;
    localparam int DEPTH_FULL = MAX_BANDS * (MAX_BANDS + 1);
    localparam int DEPTH      = (DEPTH_FULL < TABLE_CAP) ? DEPTH_FULL : TABLE_CAP;
    localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic REG_SRC = 1'b0;
    localparam logic REG_DST = 1'b1;

    logic [2:0]  src_count_reg, dst_count_reg;
    logic [31:0] table_mem [0:DEPTH-1];

    // configuration port
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_count_reg <= 3'd3;
            dst_count_reg <= 3'd3;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (paddr[2])
                REG_SRC: src_count_reg <= pwdata[2:0];
                REG_DST: dst_count_reg <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_SRC: prdata = {29'd0, src_count_reg};
            REG_DST: prdata = {29'd0, dst_count_reg};
            default: prdata = '0;
        endcase
    end

    function automatic logic [2:0] clamp_bands(input logic [2:0] n);
        if (n == 3'd0)
            return 3'd1;
        if (n > 3'(LIM))
            return 3'(LIM);
        return n;
    endfunction

    logic [2:0] ns, nd, cols;
    assign ns   = clamp_bands(src_count_reg);
    assign nd   = clamp_bands(dst_count_reg);
    assign cols = ns + 3'd1;

    // handshake and chain control
    logic             en, busy, accept, pixel_in;
    logic [LIM-1:0]   cell_busy;
    logic [1:0]       cval_reg;
    logic             out_valid_reg;

    assign en       = !out_valid_reg || out_ready;
    assign busy     = (|cell_busy) | (|cval_reg);
    assign in_ready = en && ((operation == OP_PIXEL) || !busy);
    assign accept   = in_valid && in_ready;
    assign pixel_in = accept && (operation == OP_PIXEL);

    always_ff @(posedge clk)
    begin
        if (accept && (operation == OP_WRITE) && (coef_index < 5'(DEPTH)))
            table_mem[coef_index[AW-1:0]] <= coef_value;
    end

    function automatic logic [31:0] coef_at(input logic [4:0] idx,
                                            input logic [31:0] tbl [0:DEPTH-1]);
        if (idx < 5'(DEPTH))
            return tbl[idx[AW-1:0]];
        return '0;
    endfunction

    bca_token_t tok [0:LIM];

    assign tok[0].valid = pixel_in;
    assign tok[0].src   = {src_band3, src_band2, src_band1, src_band0};
    assign tok[0].acc   = '0;

    for (genvar k = 0; k < LIM; k++)
    begin : g_cell
        logic [BANDS-1:0][31:0] coef;

        always_comb
        begin
            for (int m = 0; m < BANDS; m++)
                coef[m] = coef_at(5'(m) * {2'b00, cols} + 5'(k), table_mem);
        end

        bca_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .tok_in  (tok[k]),
            .operand (tok[k].src[k]),
            .active  (3'(k) < ns),
            .coef    (coef),
            .tok_out (tok[k+1]),
            .busy    (cell_busy[k])
        );
    end

    // constant column
    logic [BANDS-1:0][31:0] const_coef, final_sum;

    always_comb
    begin
        for (int m = 0; m < BANDS; m++)
            const_coef[m] = coef_at(5'(m) * {2'b00, cols} + {2'b00, ns}, table_mem);
    end

    for (genvar m = 0; m < BANDS; m++)
    begin : g_const
        bca_fadd u_add (
            .clk (clk),
            .en  (en),
            .a   (tok[LIM].acc[m]),
            .b   (const_coef[m]),
            .y   (final_sum[m])
        );
    end

    // output register
    logic [BANDS-1:0][31:0] dst_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cval_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            cval_reg      <= {cval_reg[0], tok[LIM].valid};
            out_valid_reg <= cval_reg[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int m = 0; m < BANDS; m++)
                dst_reg[m] <= (3'(m) < nd) ? final_sum[m] : 32'd0;
        end
    end

    assign out_valid = out_valid_reg;
    assign dst_band0 = dst_reg[0];
    assign dst_band1 = dst_reg[1];
    assign dst_band2 = dst_reg[2];
    assign dst_band3 = dst_reg[3];

endmodule
